// ===== rtl/core/integer_to_ascii_formatter_macros.svh =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: assertion macros
// Shared property shorthands for the checker. All assume i_clk and i_rst_n
// are visible in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ITAF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define ITAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/itaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Command and shift-unit codes, character constants and the digit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package itaf_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [6:0] t_char;
    typedef logic [1:0] t_op;

    // Format commands
    localparam t_cmd CMD_UDEC = 2'd0;
    localparam t_cmd CMD_SDEC = 2'd1;
    localparam t_cmd CMD_HEX  = 2'd2;
    localparam t_cmd CMD_BIN  = 2'd3;

    // Shift unit operations
    localparam t_op OP_HOLD   = 2'd0;
    localparam t_op OP_DABBLE = 2'd1;
    localparam t_op OP_NIB    = 2'd2;
    localparam t_op OP_BIT    = 2'd3;

    // Character codes
    localparam t_char ASCII_0     = 7'h30;
    localparam t_char ASCII_9     = 7'h39;
    localparam t_char ASCII_A     = 7'h41;
    localparam t_char ASCII_F     = 7'h46;
    localparam t_char ASCII_MINUS = 7'h2D;

    localparam logic [3:0] DIGIT_TEN = 4'd10;

    // One hex or BCD digit to its ASCII code
    function automatic t_char itaf_char(input logic [3:0] d);
        t_char c;
        if (d < DIGIT_TEN) begin
            c = ASCII_0 + {3'b000, d};
        end else begin
            c = ASCII_A + {3'b000, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itaf_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel of the formatter
// One beat carries a format command and the value to print.
// ----------------------------------------------------------------------------
`default_nettype none

interface itaf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/itaf_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel of the formatter
// One beat carries one ASCII character and the end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface itaf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Prints a value as unsigned decimal, signed decimal, hex or binary text,
// one character per output beat, most significant digit first.
// ----------------------------------------------------------------------------
//  channel | dir | payload               | handshake
//  i_in    | in  | command[1:0], value   | valid/ready
//  o_out   | out | char_code[6:0], last  | valid/ready
//
// Work per value, accept to next accept: decimal is a load, VALUE_WIDTH dabble
//   steps, NDEC digit slots (a dropped leading zero still uses its slot) and a
//   minus if negative; hex: load, NHEX slots; binary: load, VALUE_WIDTH bits.
// i_in.ready is high only while idle; one value is in work at a time.
// A stalled output holds the character register and freezes emission.
// Reset is synchronous, active low, and clears the sequencer and out valid.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH  = 64,
    parameter int SIGNED_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itaf_in_if.sink     i_in,
    itaf_out_if.source  o_out
);
    import itaf_pkg::*;

    localparam int NDEC = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int NHEX = (VALUE_WIDTH + 3) / 4;
    localparam int SHW  = 4 * NDEC;
    localparam int CW   = $clog2(VALUE_WIDTH + 1);

    localparam logic [63:0] VMASK = (VALUE_WIDTH >= 64) ? {64{1'b1}}
                                    : ((64'd1 << VALUE_WIDTH) - 64'd1);
    localparam logic [63:0] SMASK = (SIGNED_WIDTH >= 64) ? {64{1'b1}}
                                    : ((64'd1 << SIGNED_WIDTH) - 64'd1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_minus, n_minus;
    logic                   r_skip, n_skip;
    t_cmd                   r_cmd, n_cmd;
    logic [SHW-1:0]         r_shf, n_shf;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic                   r_ov, n_ov;
    t_char                  r_char, n_char;
    logic                   r_last, n_last;

    t_op                    w_op;
    logic [SHW-1:0]         w_shf_nx;
    logic [VALUE_WIDTH-1:0] w_bin_nx;
    logic [63:0]            w_v64, w_s64, w_mag64;
    logic                   w_neg;
    logic [SHW-1:0]         w_ext;
    logic                   w_slot;
    logic [3:0]             w_top;
    t_char                  w_top_char;

    itaf_shift_unit #(
        .SHW  (SHW),
        .BINW (VALUE_WIDTH)
    ) u_shift (
        .i_op  (w_op),
        .i_shf (r_shf),
        .i_bin (r_bin),
        .o_shf (w_shf_nx),
        .o_bin (w_bin_nx)
    );

    // Input value, signed magnitude and zero-extended load image
    assign w_v64   = i_in.value & VMASK;
    assign w_s64   = w_v64 & SMASK;
    assign w_neg   = w_s64[SIGNED_WIDTH-1];
    assign w_mag64 = w_neg ? ((~w_s64 + 64'd1) & SMASK) : w_s64;
    assign w_ext   = SHW'(w_v64[VALUE_WIDTH-1:0]);

    // Current leading digit
    assign w_top      = r_shf[SHW-1 -: 4];
    assign w_top_char = (r_cmd == CMD_BIN) ? (ASCII_0 + {6'b0, r_shf[SHW-1]})
                                           : itaf_char(w_top);

    assign w_slot = !r_ov || o_out.ready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_minus = r_minus;
        n_skip  = r_skip;
        n_cmd   = r_cmd;
        n_shf   = r_shf;
        n_bin   = r_bin;
        n_ov    = r_ov && !o_out.ready;
        n_char  = r_char;
        n_last  = r_last;
        w_op    = OP_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = i_in.command;
                    n_minus = 1'b0;
                    n_skip  = 1'b1;
                    unique case (i_in.command)
                        CMD_UDEC: begin
                            n_bin   = w_v64[VALUE_WIDTH-1:0];
                            n_shf   = '0;
                            n_cnt   = CW'(VALUE_WIDTH);
                            n_state = S_CONV;
                        end
                        CMD_SDEC: begin
                            n_bin   = w_mag64[VALUE_WIDTH-1:0];
                            n_shf   = '0;
                            n_minus = w_neg;
                            n_cnt   = CW'(VALUE_WIDTH);
                            n_state = S_CONV;
                        end
                        CMD_HEX: begin
                            n_shf   = w_ext << (SHW - 4 * NHEX);
                            n_cnt   = CW'(NHEX);
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_shf   = w_ext << (SHW - VALUE_WIDTH);
                            n_skip  = 1'b0;
                            n_cnt   = CW'(VALUE_WIDTH);
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_CONV: begin
                w_op  = OP_DABBLE;
                n_shf = w_shf_nx;
                n_bin = w_bin_nx;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_cnt   = CW'(NDEC);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_minus) begin
                    // sign goes out ahead of the digits
                    if (w_slot) begin
                        n_ov    = 1'b1;
                        n_char  = ASCII_MINUS;
                        n_last  = 1'b0;
                        n_minus = 1'b0;
                    end
                end else if (r_skip && w_top == 4'd0 && r_cnt != CW'(1)) begin
                    // drop a leading zero, no beat
                    w_op  = OP_NIB;
                    n_shf = w_shf_nx;
                    n_cnt = r_cnt - CW'(1);
                end else if (w_slot) begin
                    w_op   = (r_cmd == CMD_BIN) ? OP_BIT : OP_NIB;
                    n_shf  = w_shf_nx;
                    n_cnt  = r_cnt - CW'(1);
                    n_skip = 1'b0;
                    n_ov   = 1'b1;
                    n_char = w_top_char;
                    n_last = (r_cnt == CW'(1));
                    if (r_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_minus <= 1'b0;
            r_skip  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_minus <= n_minus;
            r_skip  <= n_skip;
            r_ov    <= n_ov;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_shf  <= n_shf;
        r_bin  <= n_bin;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/itaf_shift_unit.sv =====
// ----------------------------------------------------------------------------
// Formatter shift unit
// Shared shifter: one double-dabble step (add 3 to BCD digits >= 5, shift
// binary into BCD), a 4-bit digit shift or a 1-bit digit shift.
// ----------------------------------------------------------------------------
`default_nettype none

module itaf_shift_unit #(
    parameter int SHW  = 80,
    parameter int BINW = 64
) (
    input  itaf_pkg::t_op     i_op,
    input  logic [SHW-1:0]    i_shf,
    input  logic [BINW-1:0]   i_bin,
    output logic [SHW-1:0]    o_shf,
    output logic [BINW-1:0]   o_bin
);
    import itaf_pkg::*;

    localparam int DIGITS = SHW / 4;

    logic [SHW-1:0] w_adj;

    // BCD digit correction, each digit on its own
    always_comb begin
        w_adj = i_shf;
        for (int i = 0; i < DIGITS; i++) begin
            if (i_shf[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = i_shf[4*i +: 4] + 4'd3;
            end
        end
    end

    // Operation select
    always_comb begin
        o_shf = i_shf;
        o_bin = i_bin;
        unique case (i_op)
            OP_DABBLE: begin
                o_shf = {w_adj[SHW-2:0], i_bin[BINW-1]};
                o_bin = {i_bin[BINW-2:0], 1'b0};
            end
            OP_NIB: begin
                o_shf = {i_shf[SHW-5:0], 4'b0000};
            end
            OP_BIT: begin
                o_shf = {i_shf[SHW-2:0], 1'b0};
            end
            default: begin
                o_shf = i_shf;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/itaf_checker.sv =====
// ----------------------------------------------------------------------------
// Formatter port checker
// Watches the formatter's ports and flags illegal ready and output behavior.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"

module itaf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_last
);
    import itaf_pkg::*;

    logic w_char_ok;

    assign w_char_ok = (i_out_char >= ASCII_0 && i_out_char <= ASCII_9)
                    || (i_out_char >= ASCII_A && i_out_char <= ASCII_F)
                    || (i_out_char == ASCII_MINUS);

    // a stalled beat keeps its character and flag
    `ITAF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_char) && $stable(i_out_last), "output beat changed under stall")

    // one value in work at a time
    `ITAF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "input taken while busy")

    // only digits, hex letters and minus appear
    `ITAF_ASSERT_SAME(a_char_legal, i_out_valid, w_char_ok, "illegal character code")

    // the sign never ends a run
    `ITAF_ASSERT_SAME(a_minus_not_last, i_out_valid && i_out_char == ASCII_MINUS, !i_out_last, "minus sign marked last")

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_code),
    .i_out_last  (o_out.last)
);

`default_nettype wire
